// File: rtl/core/apc_pkg.sv
// Package for the peak compressor: types, codes, constants and the exp2 table.
`timescale 1ns / 1ps
package apc_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_SLOPE     = 3'd1,
    REG_MAKEUP    = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_CHANNELS  = 3'd5
  } reg_idx_t;

  localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
  localparam logic [15:0]        SLOPE_RST     = 16'd49152;
  localparam logic [15:0]        MAKEUP_RST    = 16'd4096;
  localparam logic [15:0]        ATTACK_RST    = 16'd65400;
  localparam logic [15:0]        RELEASE_RST   = 16'd65522;
  localparam logic [1:0]         CHANNELS_RST  = 2'd2;

  localparam logic signed [17:0] DB_FLOOR   = -18'sd24576;
  localparam logic [14:0]        LOG_DB_K   = 15'd24660;  // 20*log10(2) in Q8.8 per Q.12
  localparam logic [13:0]        EXP_K      = 14'd10885;  // log2(10)/20 scaled
  localparam int                 SQR_STEPS  = 12;
  localparam logic [16:0]        UNITY_GAIN = 17'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_A,
    S_ENV_B,
    S_NORM,
    S_SQR,
    S_DB,
    S_GAIN,
    S_LOG2,
    S_INTERP,
    S_GM,
    S_OUTL,
    S_OUTR
  } state_t;

  typedef struct packed {
    state_t state;
    logic   in_ready;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic env_zero;
    logic unity;
    logic sqr_last;
    logic out_free;
  } stat_t;

  // 2^(k/16) in Q2.15
  function automatic logic [16:0] exp2_lut(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd34219;
      5'd2:    v = 17'd35734;
      5'd3:    v = 17'd37316;
      5'd4:    v = 17'd38968;
      5'd5:    v = 17'd40693;
      5'd6:    v = 17'd42495;
      5'd7:    v = 17'd44376;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd48393;
      5'd10:   v = 17'd50535;
      5'd11:   v = 17'd52773;
      5'd12:   v = 17'd55109;
      5'd13:   v = 17'd57549;
      5'd14:   v = 17'd60097;
      5'd15:   v = 17'd62757;
      5'd16:   v = 17'd65536;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/apc_ifs.sv
// Channel interfaces of the peak compressor: samples in, results out, register writes.
`timescale 1ns / 1ps
interface apc_in_if #(parameter int SAMPLE_BITS = apc_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          frame_end;
  modport source (output valid, output sample_left, output sample_right,
                  output frame_end, input ready);
  modport sink (input valid, input sample_left, input sample_right,
                input frame_end, output ready);
endinterface

interface apc_out_if #(parameter int SAMPLE_BITS = apc_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          frame_end_out;
  modport source (output valid, output out_left, output out_right,
                  output frame_end_out, input ready);
  modport sink (input valid, input out_left, input out_right,
                input frame_end_out, output ready);
endinterface

interface apc_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [apc_pkg::CFG_IDX_W-1:0]    index;
  logic [apc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/apc_seq.sv
// Sequencer of the peak compressor: steps the shared multiplier through one sample time.
`timescale 1ns / 1ps
module apc_seq (
  input  logic           clk,
  input  logic           rst,
  input  apc_pkg::stat_t stat,
  output apc_pkg::ctrl_t ctrl
);
  import apc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (stat.accept) state_next = S_ENV_A;
      S_ENV_A:  state_next = S_ENV_B;
      S_ENV_B:  state_next = S_NORM;
      S_NORM:   state_next = stat.env_zero ? S_GAIN : S_SQR;
      S_SQR:    if (stat.sqr_last) state_next = S_DB;
      S_DB:     state_next = S_GAIN;
      S_GAIN:   state_next = stat.unity ? S_GM : S_LOG2;
      S_LOG2:   state_next = stat.unity ? S_GM : S_INTERP;
      S_INTERP: state_next = S_GM;
      S_GM:     state_next = S_OUTL;
      S_OUTL:   state_next = S_OUTR;
      S_OUTR:   if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.state    = state;
    ctrl.in_ready = (state == S_IDLE);
    ctrl.out_load = (state == S_OUTR) && stat.out_free;
  end

endmodule

// File: rtl/core/audio_peak_compressor_core.sv
// Top level of the feed-forward peak compressor with one shared multiplier.
//
//  channel  | dir | handshake     | word
//  samples  | in  | valid/ready   | sample_left, sample_right, frame_end
//  result   | out | valid/ready   | out_left, out_right, frame_end_out
//  cfg      | in  | valid/ready   | index, data (register write, always ready)
//
// Accept to result load: envelope update, normalisation, twelve log2 squaring
// steps on the shared multiplier, dB, gain, log2, interpolation, makeup, outputs.
// Unity gain skips the rest of the gain path, a zero envelope squaring and dB.
// rst is synchronous: registers return to their defaults, envelope to zero.
// A finished result waits in the output register; the next word is accepted
// meanwhile and only stalls at its last step if the result is still not taken.
`timescale 1ns / 1ps
module audio_peak_compressor_core #(
  parameter int CHANNELS    = apc_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = apc_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  apc_in_if.sink    samples,
  apc_out_if.source result,
  apc_cfg_if.sink   cfg
);
  import apc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int MB = ((SB > 17) ? SB : 17) + 1;  // multiplier port b
  localparam int MA = 35;                          // multiplier port a
  localparam int PW = MA + MB;

  // configuration registers
  logic signed [15:0] threshold_db;
  logic [15:0]        slope_q16;
  logic [15:0]        makeup_gain;
  logic [15:0]        attack_coef;
  logic [15:0]        release_coef;
  logic [1:0]         active_channels;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db    <= THRESHOLD_RST;
      slope_q16       <= SLOPE_RST;
      makeup_gain     <= MAKEUP_RST;
      attack_coef     <= ATTACK_RST;
      release_coef    <= RELEASE_RST;
      active_channels <= CHANNELS_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_THRESHOLD: threshold_db    <= $signed(cfg.data);
        REG_SLOPE:     slope_q16       <= cfg.data;
        REG_MAKEUP:    makeup_gain     <= cfg.data;
        REG_ATTACK:    attack_coef     <= cfg.data;
        REG_RELEASE:   release_coef    <= cfg.data;
        REG_CHANNELS:  active_channels <= cfg.data[1:0];
        default:       ;  // unknown index, dropped
      endcase
    end
  end

  // sequencer
  ctrl_t ctrl;
  stat_t stat;

  apc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // datapath registers
  logic signed [SB-1:0] sl, sr, res_left;
  logic                 fe, two;
  logic [15:0]          peak, coef, envelope, xv;
  logic [33:0]          acc, gm;
  logic [11:0]          frac, fpart;
  logic [3:0]           iter, p;
  logic signed [17:0]   db, gval;
  logic [6:0]           n_sh;
  logic [16:0]          gain;
  logic                 out_valid;

  // peak detect on the incoming word, magnitude scaled to 15 fraction bits
  logic [SB-1:0]    mag_l, mag_r;
  logic [SB+15:0]   wide_l, wide_r;
  logic [15:0]      pk_l, pk_r, pk;
  logic             two_in;

  always_comb begin
    mag_l  = samples.sample_left[SB-1]  ? SB'(-samples.sample_left)  : SB'(samples.sample_left);
    mag_r  = samples.sample_right[SB-1] ? SB'(-samples.sample_right) : SB'(samples.sample_right);
    wide_l = {mag_l, 16'b0} >> SB;
    wide_r = {mag_r, 16'b0} >> SB;
    pk_l   = wide_l[15:0];
    pk_r   = wide_r[15:0];
    two_in = active_channels[1] && (CHANNELS >= 2);
    pk     = (two_in && (pk_r > pk_l)) ? pk_r : pk_l;
  end

  // leading one of the envelope
  logic [3:0] pe;
  always_comb begin
    pe = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (envelope[i]) pe = 4'(i);
    end
  end

  // exp2 interpolation operands
  logic [16:0] lut_base, lut_next, lut_diff;
  always_comb begin
    lut_base = exp2_lut({1'b0, fpart[11:8]});
    lut_next = exp2_lut(5'({1'b0, fpart[11:8]} + 5'd1));
    lut_diff = lut_next - lut_base;
  end

  // shared multiplier
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [16:0]   l12;
  logic [16:0]          c_comp;
  logic signed [17:0]   d_val;

  always_comb begin
    c_comp = 17'h10000 - {1'b0, coef};
    l12    = $signed({5'({1'b0, p} - 5'd15), frac});
    ma     = '0;
    mb     = '0;
    case (ctrl.state)
      S_ENV_A:  begin ma = MA'(c_comp);      mb = MB'(peak);        end
      S_ENV_B:  begin ma = MA'(coef);        mb = MB'(envelope);    end
      S_SQR:    begin ma = MA'(xv);          mb = MB'(xv);          end
      S_DB:     begin ma = MA'(l12);         mb = MB'(LOG_DB_K);    end
      S_GAIN:   begin ma = MA'(d_val);       mb = MB'(slope_q16);   end
      S_LOG2:   begin ma = MA'(gval);        mb = MB'(EXP_K);       end
      S_INTERP: begin ma = MA'(lut_diff);    mb = MB'(fpart[7:0]);  end
      S_GM:     begin ma = MA'(gain);        mb = MB'(makeup_gain); end
      S_OUTL:   begin ma = MA'(gm);          mb = MB'(sl);          end
      S_OUTR:   begin ma = MA'(gm);          mb = MB'(sr);          end
      default:  begin ma = '0;               mb = '0;               end
    endcase
    prod = PW'(ma) * PW'(mb);
  end

  // post-multiply arithmetic
  logic [33:0]          env_sum;
  logic [16:0]          y_sq;
  logic signed [PW-1:0] rnd16, rnd12, rnd8, rnd27, y_out;
  logic signed [17:0]   db_raw;
  logic signed [18:0]   l2;
  logic [18:0]          neg;
  logic [16:0]          v_int, v_sh;
  logic [17:0]          v_rnd;
  logic [16:0]          gain_new;
  logic signed [SB-1:0] sat_y;

  always_comb begin
    d_val   = 18'(threshold_db) - db;
    env_sum = acc + prod[33:0] + 34'd32768;
    y_sq    = prod[31:15];
    rnd16   = prod + PW'(32768);
    rnd12   = prod + PW'(2048);
    rnd8    = prod + PW'(128);
    rnd27   = prod + PW'(67108864);
    db_raw  = $signed(rnd16[33:16]);
    l2      = $signed(rnd12[30:12]);
    neg     = 19'(-l2);
    v_int   = lut_base + 17'(rnd8[20:8]);
    v_sh    = v_int >> (n_sh - 7'd1);
    v_rnd   = {1'b0, v_sh} + 18'd1;
    if (n_sh > 7'd31) begin
      gain_new = '0;
    end else if (n_sh == 7'd0) begin
      gain_new = v_int;
    end else begin
      gain_new = v_rnd[17:1];
    end
    y_out = rnd27 >>> 27;
    if (y_out > PW'((2 ** (SB - 1)) - 1)) begin
      sat_y = {1'b0, {(SB-1){1'b1}}};
    end else if (y_out < -PW'(2 ** (SB - 1))) begin
      sat_y = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sat_y = y_out[SB-1:0];
    end
  end

  // status back to the sequencer
  always_comb begin
    stat.accept   = samples.valid && ctrl.in_ready;
    stat.env_zero = (envelope == 16'd0);
    stat.unity    = (ctrl.state == S_GAIN) ? !d_val[17] : !l2[18];
    stat.sqr_last = (iter == 4'(SQR_STEPS - 1));
    stat.out_free = !out_valid || result.ready;
  end

  assign samples.ready = ctrl.in_ready;

  // envelope is cleared by reset, like the step counter and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (ctrl.state == S_ENV_B) begin
      envelope <= env_sum[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (ctrl.state == S_NORM) begin
      iter <= '0;
    end else if (ctrl.state == S_SQR) begin
      iter <= iter + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.state)
      S_IDLE: begin
        if (stat.accept) begin
          sl   <= samples.sample_left;
          sr   <= samples.sample_right;
          fe   <= samples.frame_end;
          two  <= two_in;
          peak <= pk;
          coef <= (envelope < pk) ? attack_coef : release_coef;
        end
      end
      S_ENV_A: acc <= prod[33:0];
      S_NORM: begin
        // silent envelope goes straight to the dB floor
        if (envelope == 16'd0) begin
          db <= DB_FLOOR;
        end else begin
          p    <= pe;
          xv   <= envelope << (4'd15 - pe);
          frac <= '0;
        end
      end
      S_SQR: begin
        frac <= {frac[10:0], y_sq[16]};
        xv   <= y_sq[16] ? y_sq[16:1] : y_sq[15:0];
      end
      S_DB: db <= (db_raw < DB_FLOOR) ? DB_FLOOR : db_raw;
      S_GAIN: begin
        if (!d_val[17]) begin
          gain <= UNITY_GAIN;
        end else begin
          gval <= $signed(rnd16[33:16]);
        end
      end
      S_LOG2: begin
        // split l2 into -n + f/4096, f in [0,4096)
        if (!l2[18]) begin
          gain <= UNITY_GAIN;
        end else if (neg[11:0] != 12'd0) begin
          n_sh  <= neg[18:12] + 7'd1;
          fpart <= 12'(13'd4096 - {1'b0, neg[11:0]});
        end else begin
          n_sh  <= neg[18:12];
          fpart <= '0;
        end
      end
      S_INTERP: gain <= gain_new;
      S_GM:     gm <= prod[33:0];
      S_OUTL:   res_left <= sat_y;
      default:  ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      result.out_left      <= res_left;
      result.out_right     <= two ? sat_y : '0;
      result.frame_end_out <= fe;
    end
  end

  assign result.valid = out_valid;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    stat.accept |=> ctrl.state == S_ENV_A)
    else $error("accepted word did not start the envelope update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    envelope <= 16'd32768)
    else $error("envelope above full scale");

  a_sqr_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.state == S_SQR |-> iter < 4'(SQR_STEPS))
    else $error("log2 squaring ran past its step count");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.state == S_GM |-> gain <= UNITY_GAIN)
    else $error("gain above unity");

endmodule

// File: tb/sv/tb_audio_peak_compressor_core.sv
// Self-checking testbench of the peak compressor core: directed and random words.
`timescale 1ns / 1ps
module tb_audio_peak_compressor_core;
  import apc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  apc_in_if  samples ();
  apc_out_if result ();
  apc_cfg_if cfg ();

  audio_peak_compressor_core dut (
    .clk(clk), .rst(rst), .samples(samples), .result(result), .cfg(cfg)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               fe;
  } comp_word_t;

  // predictor copy of the registers and the envelope
  logic signed [15:0] thr_q;
  logic [15:0]        slope_q, makeup_q, attack_q, release_q;
  logic [1:0]         chan_q;
  logic [15:0]        env_q;

  comp_word_t pending_words[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic send_done = 1'b0;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN_CYCLES = 40;

  // round to nearest, ties up: floor((v + 2^(s-1)) / 2^s)
  function automatic longint rshift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int level_db(logic [15:0] env);
    int p;
    longint x, frac, l12, db;
    if (env == 16'd0) return -24576;
    p = 15;
    while (p > 0 && !env[p]) p--;
    x = longint'(env) << (15 - p);
    frac = 0;
    for (int i = 0; i < SQR_STEPS; i++) begin
      x = (x * x) >> 15;
      frac = frac << 1;
      if (x >= 65536) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    l12 = longint'(p) * 4096 - 15 * 4096 + frac;
    db = rshift_round(l12 * 24660, 16);
    if (db < -24576) db = -24576;
    return int'(db);
  endfunction

  function automatic longint lin_gain(int env_db);
    longint d, g, l2, neg, n, f, idx, r, v, a, b;
    d = longint'(thr_q) - env_db;
    if (d >= 0) return 32768;
    g = rshift_round(d * longint'(slope_q), 16);
    l2 = rshift_round(g * 10885, 12);
    if (l2 >= 0) return 32768;
    neg = -l2;
    n = neg >> 12;
    f = neg & 4095;
    if (f != 0) begin
      n++;
      f = 4096 - f;
    end
    idx = f >> 8;
    r = f & 255;
    a = longint'(exp2_lut(5'(idx)));
    b = longint'(exp2_lut(5'(idx + 1)));
    v = a + (((b - a) * r + 128) >> 8);
    if (n > 31) return 0;
    if (n > 0) v = (v + (64'sd1 <<< (n - 1))) >> n;
    return v;
  endfunction

  function automatic logic signed [15:0] scaled_sample(longint s, longint gain);
    longint y;
    y = rshift_round(s * gain * longint'(makeup_q), 27);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return 16'(y);
  endfunction

  // advance the envelope and return the compressed word
  function automatic comp_word_t compress_word(logic signed [15:0] sl, logic signed [15:0] sr,
                                               logic fe);
    comp_word_t w;
    logic two;
    longint pk, pr, c, e, gain;
    two = (chan_q >= 2);
    pk = (sl < 0) ? -longint'(sl) : longint'(sl);
    if (two) begin
      pr = (sr < 0) ? -longint'(sr) : longint'(sr);
      if (pr > pk) pk = pr;
    end
    c = (longint'(env_q) < pk) ? longint'(attack_q) : longint'(release_q);
    e = (pk * (65536 - c) + longint'(env_q) * c + 32768) >> 16;
    env_q = 16'(e);
    gain = lin_gain(level_db(env_q));
    w.left = scaled_sample(longint'(sl), gain);
    w.right = two ? scaled_sample(longint'(sr), gain) : 16'sd0;
    w.fe = fe;
    return w;
  endfunction

  initial begin
    samples.valid = 1'b0;
    samples.sample_left = '0;
    samples.sample_right = '0;
    samples.frame_end = 1'b0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // valid stays up between back-to-back words; it drops on sender idles and idle waits
  task automatic send_word(logic signed [15:0] sl, logic signed [15:0] sr, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample_left <= sl;
    samples.sample_right <= sr;
    samples.frame_end <= fe;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    pending_words.push_back(compress_word(sl, sr, fe));
    words_sent++;
  endtask

  // block must be idle: all results in, then the pipeline tail
  task automatic wait_idle();
    samples.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_q = val;
      REG_SLOPE:     slope_q = val;
      REG_MAKEUP:    makeup_q = val;
      REG_ATTACK:    attack_q = val;
      REG_RELEASE:   release_q = val;
      REG_CHANNELS:  chan_q = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic signed [15:0] t, logic [15:0] s, logic [15:0] m,
                           logic [15:0] a, logic [15:0] r, logic [1:0] ch);
    wait_idle();
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_SLOPE, s);
    write_reg(REG_MAKEUP, m);
    write_reg(REG_ATTACK, a);
    write_reg(REG_RELEASE, r);
    write_reg(REG_CHANNELS, {14'd0, ch});
  endtask

  // extremes of the samples, one and two channels, both coefficient extremes,
  // positive threshold, and index codes past the last register
  task automatic test_directed();
    send_word(16'sd0, 16'sd0, 1'b0);
    send_word(16'sh7fff, 16'sh8000, 1'b1);
    send_word(16'sh8000, 16'sh7fff, 1'b0);
    send_word(16'sd1, -16'sd1, 1'b1);
    send_word(16'sd0, 16'sd0, 1'b0);
    write_all(16'sd0, 16'hffff, 16'hffff, 16'd0, 16'd0, 2'd2);
    send_word(16'sh7fff, 16'sd0, 1'b0);
    send_word(16'sh8000, 16'sh8000, 1'b1);
    send_word(16'sd0, 16'sd0, 1'b0);
    send_word(16'sd100, -16'sd3000, 1'b1);
    write_all(16'sd1024, 16'd0, 16'd0, 16'hffff, 16'hffff, 2'd1);
    send_word(16'sh7fff, 16'sh8000, 1'b0);
    send_word(-16'sd20000, 16'sh7fff, 1'b1);
    write_all(-16'sd24576, 16'hffff, 16'd4096, 16'd0, 16'd65000, 2'd0);
    send_word(16'sh8000, 16'sh7fff, 1'b0);
    send_word(16'sd5, 16'sd5, 1'b0);
    write_all(16'sh7fff, 16'd32768, 16'd8192, 16'd1000, 16'd0, 2'd3);
    send_word(16'sh7fff, 16'sh8000, 1'b1);
    send_word(16'sd12, -16'sd9, 1'b0);
    // unknown register codes must leave every setting alone
    wait_idle();
    write_reg(reg_idx_t'(3'd6), 16'h1234);
    write_reg(reg_idx_t'(3'd7), 16'h5678);
    send_word(16'sh4000, 16'shc000, 1'b1);
    send_word(16'sd300, 16'sd200, 1'b0);
  endtask

  function automatic logic signed [15:0] rand_sample(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(65535, 32768));
      2: return 16'($urandom_range(255)) - 16'sd128;
      default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // random settings, random bursts of loud and quiet passages
  task automatic test_random(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        write_all(-16'($urandom_range(24576)), 16'($urandom), 16'($urandom_range(16384)),
                  ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom),
                  ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom),
                  2'($urandom_range(3)));
      end
      if (i % 20 == 0) mode = $urandom_range(3);
      send_word(rand_sample(mode), rand_sample(mode), 1'($urandom));
    end
  endtask

  task automatic test_reset_values();
    write_all(THRESHOLD_RST, SLOPE_RST, MAKEUP_RST, ATTACK_RST, RELEASE_RST, CHANNELS_RST);
    test_random(50);
  endtask

  // result side: random stall and check against the oldest expectation
  always @(posedge clk) begin
    comp_word_t w;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (pending_words.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          w = pending_words.pop_front();
          words_checked++;
          if (result.out_left !== w.left) begin
            $error("out_left expected %0d actual %0d", w.left, result.out_left);
            errors++;
          end
          if (result.out_right !== w.right) begin
            $error("out_right expected %0d actual %0d", w.right, result.out_right);
            errors++;
          end
          if (result.frame_end_out !== w.fe) begin
            $error("frame_end_out expected %0d actual %0d", w.fe, result.frame_end_out);
            errors++;
          end
        end
      end
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((samples.valid && samples.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready) || rst || send_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("audio_peak_compressor_core: mismatch");
      $finish;
    end
  end

  initial begin
    int drain;
    thr_q = THRESHOLD_RST;
    slope_q = SLOPE_RST;
    makeup_q = MAKEUP_RST;
    attack_q = ATTACK_RST;
    release_q = RELEASE_RST;
    chan_q = CHANNELS_RST;
    env_q = 16'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 76;
    test_directed();
    test_random(600);
    send_idle_pct = 76;
    recv_idle_pct = 28;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    test_reset_values();
    samples.valid <= 1'b0;
    drain = 0;
    while (pending_words.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    send_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d result words never arrived", pending_words.size());
      errors++;
    end
    $display("Sent %0d sample words, checked %0d results over several register settings,",
             words_sent, words_checked);
    $display("one and two channels, with sender and receiver stalls.");
    if (errors == 0) begin
      $display("audio_peak_compressor_core: match");
    end else begin
      $display("audio_peak_compressor_core: mismatch");
    end
    $finish;
  end

endmodule
